// ----- rtl/lhs_pkg.sv -----
package lhs_pkg;

  localparam int MAX_SAMPLES    = 1024;
  localparam int MAX_DIMENSIONS = 8;

  localparam int CELL_W = 10;
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int N_W    = ADDR_W + 1;
  localparam int COMP_W = $clog2(MAX_DIMENSIONS);
  localparam int D_W    = COMP_W + 1;
  localparam int Q_W    = 16;
  localparam int OFS_W  = 10;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 11;
  localparam int ROW_W  = MAX_DIMENSIONS * CELL_W;

  localparam logic [N_W-1:0] N_MAX = N_W'(MAX_SAMPLES);
  localparam logic [D_W-1:0] D_MAX = D_W'(MAX_DIMENSIONS);
  localparam logic [Q_W-1:0] HALF_Q16 = 16'h8000;

  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMIT    = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_SEQ   = 2'd2;

  localparam logic [IDX_W-1:0] REG_SAMPLES = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIMS    = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHIFT   = 2'd2;

  typedef enum logic [1:0] {
    RES_RESTART,
    RES_SEQ,
    RES_DRAW,
    RES_EMIT
  } res_kind_t;

  typedef struct packed {
    logic      accept;
    logic      restart;
    logic      clr_we;
    logic      draw_rd;
    logic      draw_wi;
    logic      draw_wj;
    logic      emit_rd;
    logic      div_start;
    logic      load;
    res_kind_t kind;
  } dp_ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic draw_ok;
    logic emit_ok;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/lhs_if.sv -----
interface lhs_req_if
  import lhs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [OFS_W-1:0] offset;
  logic [Q_W-1:0]   jitter;

  modport source (output valid, cmd, offset, jitter, input ready);
  modport sink (input valid, cmd, offset, jitter, output ready);
endinterface

interface lhs_rsp_if
  import lhs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [Q_W-1:0]    coordinate;
  logic [CELL_W-1:0] cell_res;
  logic [ADDR_W-1:0] sample_index;
  logic [COMP_W-1:0] component_index;
  logic              last;
  logic [ST_W-1:0]   status;

  modport source (
    output valid, coordinate, cell_res, sample_index, component_index, last, status,
    input ready
  );
  modport sink (
    input valid, coordinate, cell_res, sample_index, component_index, last, status,
    output ready
  );
endinterface

// ----- rtl/lhs_div.sv -----
module lhs_div
  import lhs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CELL_W-1:0] cell_in,
  input  logic [Q_W-1:0]    jitter,
  input  logic [N_W-1:0]    divisor,
  output logic              done,
  output logic [Q_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [N_W-1:0]   rem;
  logic [Q_W-1:0]   lo;
  logic [Q_W-1:0]   quot;
  logic [CNT_W-1:0] cnt;
  logic [N_W:0]     trial;
  logic [N_W:0]     diff;
  logic             ge;

  // Restoring division: the remainder stays below the divisor, so one
  // quotient bit comes out per cycle over the sixteen fraction bits.
  assign trial = {rem, lo[Q_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      rem  <= N_W'(cell_in);
      lo   <= jitter;
      cnt  <= CNT_W'(Q_W);
    end else if (cnt != '0) begin
      rem  <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
      lo   <= {lo[Q_W-2:0], 1'b0};
      quot <= {quot[Q_W-2:0], ge};
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign done     = (cnt == '0);
  assign quotient = quot;

endmodule

// ----- rtl/lhs_dp.sv -----
module lhs_dp
  import lhs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_ctrl_t          ctrl,
  output dp_stat_t          stat,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [OFS_W-1:0]  in_offset,
  input  logic [Q_W-1:0]    in_jitter,
  lhs_rsp_if.source         rsp
);

  logic [CFG_W-1:0]  sample_count;
  logic [D_W-1:0]    dimension_count;
  logic              random_shift;
  logic [ADDR_W-1:0] swap_index;
  logic [COMP_W-1:0] draw_component;
  logic [ADDR_W-1:0] emit_sample;
  logic [COMP_W-1:0] emit_component;
  logic              shuffle_done;
  logic              need_restart;
  logic [ADDR_W-1:0] clr_addr;
  logic [OFS_W-1:0]  offset_q;
  logic [Q_W-1:0]    jitter_q;

  logic [ROW_W-1:0]  mem [MAX_SAMPLES];
  logic [ROW_W-1:0]  rd_a;
  logic [ROW_W-1:0]  rd_b;

  logic [N_W-1:0]    n_eff;
  logic [D_W-1:0]    d_eff;
  logic              in_range;
  logic [ADDR_W-1:0] j_addr;
  logic [CELL_W-1:0] a_cell;
  logic [CELL_W-1:0] b_cell;
  logic [CELL_W-1:0] e_cell;
  logic [CELL_W-1:0] draw_cell;
  logic              draw_row_end;
  logic              draw_last;
  logic              emit_row_end;
  logic              emit_last;
  logic              size_wr;
  logic [ROW_W-1:0]  id_row;
  logic [ROW_W-1:0]  row_i_new;
  logic [ROW_W-1:0]  row_j_new;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_row;
  logic              div_done;
  logic [Q_W-1:0]    quotient;
  logic              out_valid;

  always_comb begin
    if (sample_count == '0) begin
      n_eff = N_W'(1);
    end else if (N_W'(sample_count) > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = N_W'(sample_count);
    end
    if (dimension_count == '0) begin
      d_eff = D_W'(1);
    end else if (dimension_count > D_MAX) begin
      d_eff = D_MAX;
    end else begin
      d_eff = dimension_count;
    end
  end

  assign in_range  = N_W'(offset_q) < (n_eff - N_W'(swap_index));
  assign j_addr    = swap_index + ADDR_W'(offset_q);
  assign a_cell    = rd_a[draw_component * CELL_W +: CELL_W];
  assign b_cell    = rd_b[draw_component * CELL_W +: CELL_W];
  assign e_cell    = rd_a[emit_component * CELL_W +: CELL_W];
  assign draw_cell = in_range ? b_cell : a_cell;

  assign draw_row_end = (D_W'(draw_component) + D_W'(1)) >= d_eff;
  assign draw_last    = draw_row_end && ((N_W'(swap_index) + N_W'(2)) >= n_eff);
  assign emit_row_end = (D_W'(emit_component) + D_W'(1)) >= d_eff;
  assign emit_last    = emit_row_end && ((N_W'(emit_sample) + N_W'(1)) >= n_eff);

  assign size_wr = cfg_we && (cfg_index == REG_SAMPLES || cfg_index == REG_DIMS);

  always_comb begin
    for (int d = 0; d < MAX_DIMENSIONS; d++) begin
      id_row[d*CELL_W +: CELL_W] = CELL_W'(clr_addr);
      row_i_new[d*CELL_W +: CELL_W] = (COMP_W'(d) == draw_component) ?
                                      b_cell : rd_a[d*CELL_W +: CELL_W];
      row_j_new[d*CELL_W +: CELL_W] = (COMP_W'(d) == draw_component) ?
                                      a_cell : rd_b[d*CELL_W +: CELL_W];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_row  = id_row;
    priority if (ctrl.clr_we) begin
      wr_en = 1'b1;
    end else if (ctrl.draw_wi) begin
      wr_en   = in_range;
      wr_addr = swap_index;
      wr_row  = row_i_new;
    end else if (ctrl.draw_wj) begin
      wr_en   = in_range;
      wr_addr = j_addr;
      wr_row  = row_j_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (ctrl.draw_rd) begin
      rd_a <= mem[swap_index];
      rd_b <= mem[j_addr];
    end else if (ctrl.emit_rd) begin
      rd_a <= mem[emit_sample];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      offset_q <= in_offset;
      jitter_q <= in_jitter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= CFG_W'(16);
      dimension_count <= D_W'(2);
      random_shift    <= 1'b0;
      swap_index      <= '0;
      draw_component  <= '0;
      emit_sample     <= '0;
      emit_component  <= '0;
      shuffle_done    <= 1'b0;
      need_restart    <= 1'b0;
      clr_addr        <= '0;
    end else begin
      if (ctrl.clr_we) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLES: sample_count <= cfg_data;
          REG_DIMS:    dimension_count <= cfg_data[D_W-1:0];
          REG_SHIFT:   random_shift <= cfg_data[0];
          default:     ;
        endcase
      end
      priority if (ctrl.restart) begin
        swap_index     <= '0;
        draw_component <= '0;
        emit_sample    <= '0;
        emit_component <= '0;
        need_restart   <= 1'b0;
        shuffle_done   <= (n_eff <= N_W'(1));
      end else if (size_wr) begin
        swap_index     <= '0;
        draw_component <= '0;
        emit_sample    <= '0;
        emit_component <= '0;
        need_restart   <= 1'b1;
        shuffle_done   <= 1'b0;
      end else if (ctrl.load && ctrl.kind == RES_DRAW) begin
        if (draw_row_end) begin
          draw_component <= '0;
          swap_index     <= swap_index + ADDR_W'(1);
          if (draw_last) begin
            shuffle_done <= 1'b1;
          end
        end else begin
          draw_component <= draw_component + COMP_W'(1);
        end
      end else if (ctrl.load && ctrl.kind == RES_EMIT) begin
        if (emit_row_end) begin
          emit_component <= '0;
          emit_sample    <= emit_last ? '0 : emit_sample + ADDR_W'(1);
        end else begin
          emit_component <= emit_component + COMP_W'(1);
        end
      end
    end
  end

  lhs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .cell_in  (e_cell),
    .jitter   (random_shift ? jitter_q : HALF_Q16),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      unique case (ctrl.kind)
        RES_DRAW: begin
          rsp.coordinate      <= '0;
          rsp.cell_res        <= draw_cell;
          rsp.sample_index    <= swap_index;
          rsp.component_index <= draw_component;
          rsp.last            <= draw_last;
          rsp.status          <= in_range ? ST_OK : ST_RANGE;
        end
        RES_EMIT: begin
          rsp.coordinate      <= quotient;
          rsp.cell_res        <= e_cell;
          rsp.sample_index    <= emit_sample;
          rsp.component_index <= emit_component;
          rsp.last            <= emit_last;
          rsp.status          <= ST_OK;
        end
        RES_SEQ: begin
          rsp.coordinate      <= '0;
          rsp.cell_res        <= '0;
          rsp.sample_index    <= '0;
          rsp.component_index <= '0;
          rsp.last            <= 1'b0;
          rsp.status          <= ST_SEQ;
        end
        default: begin
          rsp.coordinate      <= '0;
          rsp.cell_res        <= '0;
          rsp.sample_index    <= '0;
          rsp.component_index <= '0;
          rsp.last            <= 1'b0;
          rsp.status          <= ST_OK;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;

  assign stat.clr_last = (clr_addr == '1);
  assign stat.draw_ok  = !need_restart && !shuffle_done &&
                         ((N_W'(swap_index) + N_W'(1)) < n_eff) &&
                         (D_W'(draw_component) < d_eff);
  assign stat.emit_ok  = !need_restart && shuffle_done &&
                         (N_W'(emit_sample) < n_eff) &&
                         (D_W'(emit_component) < d_eff);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || rsp.ready;

endmodule

// ----- rtl/lhs_ctrl.sv -----
module lhs_ctrl
  import lhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  dp_stat_t         stat,
  output dp_ctrl_t         ctrl
);

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_CLEAR,
    S_DRAW_RD,
    S_DRAW_WI,
    S_DRAW_WJ,
    S_EMIT_RD,
    S_EMIT_GO,
    S_EMIT_DIV,
    S_RESP
  } state_t;

  state_t    state;
  state_t    state_next;
  res_kind_t kind;
  res_kind_t kind_next;

  always_comb begin
    ctrl       = '0;
    ctrl.kind  = kind;
    in_ready   = (state == S_IDLE);
    state_next = state;
    kind_next  = kind;
    unique case (state)
      S_BOOT: begin
        ctrl.clr_we = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          unique case (in_cmd)
            CMD_RESTART: begin
              ctrl.restart = 1'b1;
              state_next   = S_CLEAR;
              kind_next    = RES_RESTART;
            end
            CMD_DRAW: begin
              state_next = stat.draw_ok ? S_DRAW_RD : S_RESP;
              kind_next  = stat.draw_ok ? RES_DRAW : RES_SEQ;
            end
            CMD_EMIT: begin
              state_next = stat.emit_ok ? S_EMIT_RD : S_RESP;
              kind_next  = stat.emit_ok ? RES_EMIT : RES_SEQ;
            end
            default: begin
              state_next = S_RESP;
              kind_next  = RES_SEQ;
            end
          endcase
        end
      end
      S_CLEAR: begin
        ctrl.clr_we = 1'b1;
        if (stat.clr_last) begin
          state_next = S_RESP;
        end
      end
      S_DRAW_RD: begin
        ctrl.draw_rd = 1'b1;
        state_next   = S_DRAW_WI;
      end
      S_DRAW_WI: begin
        ctrl.draw_wi = 1'b1;
        state_next   = S_DRAW_WJ;
      end
      S_DRAW_WJ: begin
        ctrl.draw_wj = 1'b1;
        state_next   = S_RESP;
      end
      S_EMIT_RD: begin
        ctrl.emit_rd = 1'b1;
        state_next   = S_EMIT_GO;
      end
      S_EMIT_GO: begin
        ctrl.div_start = 1'b1;
        state_next     = S_EMIT_DIV;
      end
      S_EMIT_DIV: begin
        if (stat.div_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctrl.load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
      kind  <= RES_RESTART;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

// ----- rtl/latin_hypercube_shuffle_sampler_top.sv -----
// Channel  Dir  Handshake            Payload
// req      in   req.valid/req.ready  cmd, offset, jitter
// rsp      out  rsp.valid/rsp.ready  coordinate, cell_res, sample_index,
//                                    component_index, last, status
// cfg      in   cfg_we               cfg_index, cfg_data
//
// One transaction is in flight at a time. A draw reads two table rows, then writes each
// swapped row in turn, then loads its result. An emit reads a table row, then runs the
// restoring divider for (cell + jitter) / N and loads the quotient as its result.
// Restart and reset each run a clearing pass over the whole table, one table row per cycle,
// with req.ready low; after reset no result is given.
// A finished result waits in the output register while rsp.ready is low; req.ready
// rises again once the result has been loaded there.
module latin_hypercube_shuffle_sampler_top
  import lhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  lhs_req_if.sink          req,
  lhs_rsp_if.source        rsp
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  lhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .in_ready (req.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  lhs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_offset (req.offset),
    .in_jitter (req.jitter),
    .rsp       (rsp)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while another is in progress");

  a_coord_only_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.coordinate == '0))
    else $error("nonzero coordinate on a flagged result");

  a_seq_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_SEQ) |->
      (rsp.cell_res == '0 && rsp.sample_index == '0 &&
       rsp.component_index == '0 && !rsp.last))
    else $error("sequence error result carries data");

endmodule
